// ----- rtl/button_column_mode_decoder_core_defines.svh -----
// Assertion macros shared by the button column mode decoder RTL.
`ifndef BUTTON_COLUMN_MODE_DECODER_CORE_DEFINES_SVH
`define BUTTON_COLUMN_MODE_DECODER_CORE_DEFINES_SVH

// Check a same-cycle implication on i_clk, skipped while i_rst_n is low.
`define BCMD_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check an implication in the cycle after pre on i_clk, skipped while i_rst_n is low.
`define BCMD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/bcmd_pkg.sv -----
// Types and constants of the button column mode decoder.
package bcmd_pkg;

    typedef enum logic [1:0] {
        KIND_SCAN      = 2'd0,
        KIND_ARP_USED  = 2'd1,
        KIND_PROG_USED = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

    // Button positions within the status word
    localparam int BIT_ARP  = 0;
    localparam int BIT_TAP  = 1;
    localparam int BIT_SUS  = 2;
    localparam int BIT_PROG = 3;
    localparam int BIT_DOWN = 4;
    localparam int BIT_UP   = 5;

    localparam logic [3:0]  OCT_DEFAULT = 4'd4;
    localparam logic [3:0]  OCT_MAX     = 4'd8;
    localparam logic [3:0]  OCT_MIN     = 4'd0;
    localparam logic [15:0] HOLD_RESET  = 16'd2000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  status;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic       sustain_event;
        logic       sustain_on;
        logic       tap_event;
        logic       arp_notes_off;
        logic       keys_notes_off;
        logic       editor_toggle;
        logic       arp_enabled;
        logic       arp_latched;
        logic [3:0] octave;
        logic       program_held;
        logic       arp_held;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  last_buttons;
        logic        arp_used;
        logic        prog_used;
        logic        editor_sent;
        logic [31:0] press_time;
        logic        arp_on;
        logic        arp_latch;
        logic [3:0]  octave_value;
    } t_state;

endpackage

// ----- rtl/bcmd_in_if.sv -----
// Input channel of the button column mode decoder: valid/ready plus scan word.
interface bcmd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  status;
    logic [31:0] now_ms;

    modport source (output valid, output kind, output status, output now_ms, input ready);
    modport sink   (input valid, input kind, input status, input now_ms, output ready);
endinterface

// ----- rtl/bcmd_out_if.sv -----
// Output channel of the button column mode decoder: valid/ready plus result word.
interface bcmd_out_if;
    logic       valid;
    logic       ready;
    logic       sustain_event;
    logic       sustain_on;
    logic       tap_event;
    logic       arp_notes_off;
    logic       keys_notes_off;
    logic       editor_toggle;
    logic       arp_enabled;
    logic       arp_latched;
    logic [3:0] octave;
    logic       program_held;
    logic       arp_held;

    modport source (
        output valid, input ready,
        output sustain_event, output sustain_on, output tap_event,
        output arp_notes_off, output keys_notes_off, output editor_toggle,
        output arp_enabled, output arp_latched, output octave,
        output program_held, output arp_held
    );
    modport sink (
        input valid, output ready,
        input sustain_event, input sustain_on, input tap_event,
        input arp_notes_off, input keys_notes_off, input editor_toggle,
        input arp_enabled, input arp_latched, input octave,
        input program_held, input arp_held
    );
endinterface

// ----- rtl/bcmd_in_stage.sv -----
// Input register of the button column mode decoder.
module bcmd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bcmd_in_if.sink             i_in,
    input  logic                i_advance,
    output logic                o_valid,
    output bcmd_pkg::t_in_word  o_word
);

    logic               r_valid;
    bcmd_pkg::t_in_word r_word;
    logic               w_take;

    // Take a new word when empty or when the held word moves on this cycle
    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word.kind   <= i_in.kind;
            r_word.status <= i_in.status;
            r_word.now_ms <= i_in.now_ms;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/bcmd_step.sv -----
// Decode logic: next state and result for one word of the button column decoder.
module bcmd_step (
    input  bcmd_pkg::t_state    i_state,
    input  bcmd_pkg::t_in_word  i_word,
    input  logic [15:0]         i_hold_ms,
    output bcmd_pkg::t_state    o_state,
    output bcmd_pkg::t_out_word o_result
);

    logic [7:0]  w_chg;
    logic [31:0] w_elapsed;
    logic [31:0] w_press_time;
    logic [7:0]  w_st;

    assign w_st      = i_word.status;
    assign w_chg     = w_st ^ i_state.last_buttons;
    // Press time as it stands after this word: a program press restarts it
    assign w_press_time = (w_chg[bcmd_pkg::BIT_PROG] && w_st[bcmd_pkg::BIT_PROG])
                          ? i_word.now_ms : i_state.press_time;
    assign w_elapsed = i_word.now_ms - w_press_time;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (bcmd_pkg::t_kind'(i_word.kind))
            bcmd_pkg::KIND_ARP_USED: begin
                o_state.arp_used = 1'b1;
            end
            bcmd_pkg::KIND_PROG_USED: begin
                o_state.prog_used = 1'b1;
            end
            bcmd_pkg::KIND_NONE: begin
                o_state = i_state;
            end
            bcmd_pkg::KIND_SCAN: begin
                o_state.last_buttons = w_st;

                // Arp: press clears the used mark, release silences and maybe toggles
                if (w_chg[bcmd_pkg::BIT_ARP]) begin
                    if (w_st[bcmd_pkg::BIT_ARP]) begin
                        o_state.arp_used = 1'b0;
                    end else begin
                        o_result.arp_notes_off = 1'b1;
                        if (!i_state.arp_used) begin
                            o_state.arp_on = !i_state.arp_on;
                        end
                    end
                end

                // Program: press silences and starts the hold timer; any change clears the used and sent marks
                if (w_chg[bcmd_pkg::BIT_PROG]) begin
                    if (w_st[bcmd_pkg::BIT_PROG]) begin
                        o_result.keys_notes_off = 1'b1;
                        o_result.arp_notes_off  = 1'b1;
                        o_state.press_time      = i_word.now_ms;
                    end
                    o_state.prog_used   = 1'b0;
                    o_state.editor_sent = 1'b0;
                end

                if (w_st[bcmd_pkg::BIT_PROG] && !o_state.prog_used && !o_state.editor_sent
                    && (w_elapsed >= {16'd0, i_hold_ms})) begin
                    o_result.editor_toggle = 1'b1;
                    o_state.editor_sent    = 1'b1;
                end

                // Sustain: latch toggle while the arp runs, sustain level otherwise
                if (w_chg[bcmd_pkg::BIT_SUS]) begin
                    if (o_state.arp_on) begin
                        if (w_st[bcmd_pkg::BIT_SUS]) begin
                            o_state.arp_latch = !i_state.arp_latch;
                        end
                    end else begin
                        o_result.sustain_event = 1'b1;
                        o_result.sustain_on    = w_st[bcmd_pkg::BIT_SUS];
                    end
                end

                o_result.tap_event = w_chg[bcmd_pkg::BIT_TAP] && w_st[bcmd_pkg::BIT_TAP];

                // Octave: both held restores default, else step and clamp
                if (w_chg[bcmd_pkg::BIT_DOWN] || w_chg[bcmd_pkg::BIT_UP]) begin
                    if (w_st[bcmd_pkg::BIT_DOWN] && w_st[bcmd_pkg::BIT_UP]) begin
                        o_state.octave_value = bcmd_pkg::OCT_DEFAULT;
                    end else if (w_st[bcmd_pkg::BIT_UP]) begin
                        if (i_state.octave_value < bcmd_pkg::OCT_MAX) begin
                            o_state.octave_value = i_state.octave_value + 4'd1;
                        end
                    end else if (w_st[bcmd_pkg::BIT_DOWN]) begin
                        if (i_state.octave_value > bcmd_pkg::OCT_MIN) begin
                            o_state.octave_value = i_state.octave_value - 4'd1;
                        end
                    end
                end
            end
        endcase

        o_result.arp_enabled  = o_state.arp_on;
        o_result.arp_latched  = o_state.arp_latch;
        o_result.octave       = o_state.octave_value;
        o_result.program_held = o_state.last_buttons[bcmd_pkg::BIT_PROG];
        o_result.arp_held     = o_state.last_buttons[bcmd_pkg::BIT_ARP];
    end

endmodule

// ----- rtl/bcmd_out_stage.sv -----
// Result register of the button column mode decoder.
module bcmd_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  bcmd_pkg::t_out_word  i_word,
    output logic                 o_can_load,
    bcmd_out_if.source           o_out
);

    logic                r_valid;
    bcmd_pkg::t_out_word r_word;

    // Refill when empty or when the held word is taken this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.sustain_event  = r_word.sustain_event;
    assign o_out.sustain_on     = r_word.sustain_on;
    assign o_out.tap_event      = r_word.tap_event;
    assign o_out.arp_notes_off  = r_word.arp_notes_off;
    assign o_out.keys_notes_off = r_word.keys_notes_off;
    assign o_out.editor_toggle  = r_word.editor_toggle;
    assign o_out.arp_enabled    = r_word.arp_enabled;
    assign o_out.arp_latched    = r_word.arp_latched;
    assign o_out.octave         = r_word.octave;
    assign o_out.program_held   = r_word.program_held;
    assign o_out.arp_held       = r_word.arp_held;

endmodule

// ----- rtl/button_column_mode_decoder_core.sv -----
// Top level of the button column mode decoder.
`include "button_column_mode_decoder_core_defines.svh"

// The decoder turns scanned button-column words (arp, tap, sustain, program,
// octave down, octave up) plus "setting used" marks into one result word per
// input word: note-off, tap, sustain, latch and editor pulses together with
// the current arp flags, octave and held modifiers. It sustains one word per
// clock while the receiver takes every result: an accepted word sits in the
// input register, and once the result register is free or being emptied a
// single decode stage updates the button state and loads the result register,
// which then offers the result to the receiver. While a finished result waits on
// the receiver, the result register holds it, the input register takes at
// most one more word and then input ready drops until the result is taken.
// The editor hold time (ms, reset 2000) is to be written through i_cfg_we/i_cfg_data
// only while no word is in flight, which the block itself does not enforce; the
// hold is measured as the wrapping difference of scan time and program press time.
module button_column_mode_decoder_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_data,
    bcmd_in_if.sink      i_in,
    bcmd_out_if.source   o_out
);

    logic                r_in_valid_q;
    bcmd_pkg::t_in_word  w_in_word;
    logic                w_can_load;
    logic                w_advance;
    logic [15:0]         r_hold_ms;
    bcmd_pkg::t_state    r_state;
    bcmd_pkg::t_state    n_state;
    bcmd_pkg::t_out_word w_result;

    // Hold the input word until the result register can take its result
    bcmd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (r_in_valid_q),
        .o_word    (w_in_word)
    );

    // Advance the held word through decode exactly when the result slot is free
    assign w_advance = r_in_valid_q && w_can_load;

    bcmd_step u_step (
        .i_state   (r_state),
        .i_word    (w_in_word),
        .i_hold_ms (r_hold_ms),
        .o_state   (n_state),
        .o_result  (w_result)
    );

    // Commit the decoder state only with the word that moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_buttons <= '0;
            r_state.arp_used     <= 1'b0;
            r_state.prog_used    <= 1'b0;
            r_state.editor_sent  <= 1'b0;
            r_state.press_time   <= '0;
            r_state.arp_on       <= 1'b0;
            r_state.arp_latch    <= 1'b0;
            r_state.octave_value <= bcmd_pkg::OCT_DEFAULT;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Editor hold time register, write only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms <= bcmd_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            r_hold_ms <= i_cfg_data;
        end
    end

    bcmd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance),
        .i_word     (w_result),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

    // Octave never leaves its clamp range
    `BCMD_ASSERT_NOW(a_octave_range, 1'b1, r_state.octave_value <= bcmd_pkg::OCT_MAX, "octave out of range")
    // A sustain level only goes out with a sustain event
    `BCMD_ASSERT_NOW(a_sus_level, o_out.valid && o_out.sustain_on, o_out.sustain_event, "sustain_on without event")
    // A program press silences both keys and arp, with program held
    `BCMD_ASSERT_NOW(a_prog_press, o_out.valid && o_out.keys_notes_off, o_out.arp_notes_off && o_out.program_held, "program press pulses inconsistent")
    // The editor toggle fires only while program is held
    `BCMD_ASSERT_NOW(a_editor_held, o_out.valid && o_out.editor_toggle, o_out.program_held, "editor toggle without program held")
    // A decoded word shows up in the result register on the next edge
    `BCMD_ASSERT_NEXT(a_result_loaded, w_advance, o_out.valid, "decoded word not presented")

endmodule

// ----- dv/bcmd_result_checker.sv -----
`timescale 1ns / 1ps
// Predicts each result word of the button column mode decoder and compares it with the DUT.
module bcmd_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    bcmd_in_if          i_in_ch,
    bcmd_out_if         i_out_ch,
    output int          o_fail_count,
    output int          o_outstanding
);

    bcmd_pkg::t_state    btn_state;
    logic [15:0]         hold_ms;
    bcmd_pkg::t_out_word pending_results[$];
    int                  fail_tally;

    // Decode one word, advance the button state and return the result word.
    function automatic bcmd_pkg::t_out_word decode_word(input bcmd_pkg::t_in_word w);
        bcmd_pkg::t_out_word r;
        logic [7:0]          chg;
        logic [31:0]         elapsed;
        r = '0;
        case (bcmd_pkg::t_kind'(w.kind))
            bcmd_pkg::KIND_ARP_USED:  btn_state.arp_used = 1'b1;
            bcmd_pkg::KIND_PROG_USED: btn_state.prog_used = 1'b1;
            bcmd_pkg::KIND_SCAN: begin
                chg = w.status ^ btn_state.last_buttons;
                btn_state.last_buttons = w.status;
                if (chg[bcmd_pkg::BIT_ARP]) begin
                    if (w.status[bcmd_pkg::BIT_ARP]) begin
                        btn_state.arp_used = 1'b0;
                    end else begin
                        r.arp_notes_off = 1'b1;
                        if (!btn_state.arp_used)
                            btn_state.arp_on = ~btn_state.arp_on;
                    end
                end
                if (chg[bcmd_pkg::BIT_PROG]) begin
                    if (w.status[bcmd_pkg::BIT_PROG]) begin
                        r.keys_notes_off = 1'b1;
                        r.arp_notes_off  = 1'b1;
                        btn_state.press_time = w.now_ms;
                    end
                    btn_state.prog_used   = 1'b0;
                    btn_state.editor_sent = 1'b0;
                end
                elapsed = w.now_ms - btn_state.press_time;
                if (w.status[bcmd_pkg::BIT_PROG] && !btn_state.prog_used &&
                    !btn_state.editor_sent && elapsed >= {16'd0, hold_ms}) begin
                    r.editor_toggle = 1'b1;
                    btn_state.editor_sent = 1'b1;
                end
                if (chg[bcmd_pkg::BIT_SUS]) begin
                    if (btn_state.arp_on) begin
                        if (w.status[bcmd_pkg::BIT_SUS])
                            btn_state.arp_latch = ~btn_state.arp_latch;
                    end else begin
                        r.sustain_event = 1'b1;
                        r.sustain_on    = w.status[bcmd_pkg::BIT_SUS];
                    end
                end
                if (chg[bcmd_pkg::BIT_TAP] && w.status[bcmd_pkg::BIT_TAP])
                    r.tap_event = 1'b1;
                if (chg[bcmd_pkg::BIT_DOWN] || chg[bcmd_pkg::BIT_UP]) begin
                    if (w.status[bcmd_pkg::BIT_DOWN] && w.status[bcmd_pkg::BIT_UP]) begin
                        btn_state.octave_value = bcmd_pkg::OCT_DEFAULT;
                    end else if (w.status[bcmd_pkg::BIT_UP]) begin
                        if (btn_state.octave_value < bcmd_pkg::OCT_MAX)
                            btn_state.octave_value = btn_state.octave_value + 4'd1;
                    end else if (w.status[bcmd_pkg::BIT_DOWN]) begin
                        if (btn_state.octave_value > bcmd_pkg::OCT_MIN)
                            btn_state.octave_value = btn_state.octave_value - 4'd1;
                    end
                end
            end
            default: ;
        endcase
        r.arp_enabled  = btn_state.arp_on;
        r.arp_latched  = btn_state.arp_latch;
        r.octave       = btn_state.octave_value;
        r.program_held = btn_state.last_buttons[bcmd_pkg::BIT_PROG];
        r.arp_held     = btn_state.last_buttons[bcmd_pkg::BIT_ARP];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fail_tally++;
        end
    endtask

    always @(posedge i_clk) begin
        bcmd_pkg::t_in_word  in_word;
        bcmd_pkg::t_out_word exp_word;
        if (!i_rst_n) begin
            btn_state = '0;
            btn_state.octave_value = bcmd_pkg::OCT_DEFAULT;
            hold_ms    = bcmd_pkg::HOLD_RESET;
            fail_tally = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_we)
                hold_ms = i_cfg_data;
            if (i_in_ch.valid && i_in_ch.ready) begin
                in_word.kind   = i_in_ch.kind;
                in_word.status = i_in_ch.status;
                in_word.now_ms = i_in_ch.now_ms;
                pending_results.push_back(decode_word(in_word));
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no expectation waiting");
                    fail_tally++;
                end else begin
                    exp_word = pending_results.pop_front();
                    check_field("sustain_event", exp_word.sustain_event, i_out_ch.sustain_event);
                    check_field("sustain_on", exp_word.sustain_on, i_out_ch.sustain_on);
                    check_field("tap_event", exp_word.tap_event, i_out_ch.tap_event);
                    check_field("arp_notes_off", exp_word.arp_notes_off, i_out_ch.arp_notes_off);
                    check_field("keys_notes_off", exp_word.keys_notes_off,
                                i_out_ch.keys_notes_off);
                    check_field("editor_toggle", exp_word.editor_toggle, i_out_ch.editor_toggle);
                    check_field("arp_enabled", exp_word.arp_enabled, i_out_ch.arp_enabled);
                    check_field("arp_latched", exp_word.arp_latched, i_out_ch.arp_latched);
                    check_field("octave", exp_word.octave, i_out_ch.octave);
                    check_field("program_held", exp_word.program_held, i_out_ch.program_held);
                    check_field("arp_held", exp_word.arp_held, i_out_ch.arp_held);
                end
            end
        end
        o_outstanding <= pending_results.size();
        o_fail_count  <= fail_tally;
    end

endmodule

// ----- dv/tb_button_column_mode_decoder_core.sv -----
`timescale 1ns / 1ps
// Testbench top of the button column mode decoder: clock, reset, stimulus and verdict.
module tb_button_column_mode_decoder_core;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    bcmd_in_if  in_ch();
    bcmd_out_if out_ch();

    int          fail_count;
    int          outstanding;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;

    // Scan time and held buttons carried across the random word stream
    logic [31:0] scan_ms;
    logic [7:0]  buttons;
    logic [15:0] hold_now;

    button_column_mode_decoder_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Checker sits beside the DUT, watching both channels and the config port
    bcmd_result_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_ch       (in_ch),
        .i_out_ch      (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stall at random, one decision per edge
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Present one word, idling first at random, and hold it until accepted.
    // Inputs sampled right after the edge still carry their pre-edge values.
    task automatic send_word(input bcmd_pkg::t_kind kind, input logic [7:0] status,
                             input logic [31:0] now_ms);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.kind   <= kind;
        in_ch.status <= status;
        in_ch.now_ms <= now_ms;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic scan(input logic [7:0] status, input logic [31:0] now_ms);
        send_word(bcmd_pkg::KIND_SCAN, status, now_ms);
    endtask

    // Drop valid and hold off until every expected result word has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_hold(input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        hold_now  = value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Advance the scan clock; steps scale with the hold time so the editor
    // toggle both fires and misses. Jump anywhere now and then to hit wrap.
    task automatic advance_time();
        if ($urandom_range(0, 99) < 3)
            scan_ms = $urandom;
        else
            scan_ms = scan_ms + $urandom_range(0, hold_now / 2 + 3);
    endtask

    task automatic run_directed();
        // Idle scan at time zero, then arp press and release toggles the arp on
        scan(8'h00, 32'd0);
        scan(8'h01, 32'd10);
        scan(8'h00, 32'd20);
        // Sustain with arp on: press flips the latch, release sends nothing
        scan(8'h04, 32'd30);
        scan(8'h00, 32'd40);
        // Arp marked used while held: release silences but keeps arp on
        scan(8'h01, 32'd50);
        send_word(bcmd_pkg::KIND_ARP_USED, 8'h00, 32'd0);
        scan(8'h00, 32'd60);
        // Arp release and sustain press together: sustain sees arp already off
        scan(8'h01, 32'd70);
        scan(8'h04, 32'd80);
        scan(8'h00, 32'd90);
        scan(8'h02, 32'd100);
        // Program hold: editor fires exactly once at the hold time
        scan(8'h08, 32'd1000);
        scan(8'h08, 32'd2999);
        scan(8'h08, 32'd3000);
        scan(8'h08, 32'd9000);
        scan(8'h00, 32'd9001);
        // Program hold across the wrap of the millisecond clock
        scan(8'h08, 32'hFFFF_FC00);
        scan(8'h08, 32'h0000_0400);
        // Program marked used: no editor toggle however long it is held
        scan(8'h00, 32'h0000_0500);
        scan(8'h08, 32'h0000_0600);
        send_word(bcmd_pkg::KIND_PROG_USED, 8'hFF, 32'hFFFF_FFFF);
        scan(8'h08, 32'h0001_0000);
        // Octave up, then both held restores the default
        scan(8'h20, 32'h0001_0001);
        scan(8'h30, 32'h0001_0002);
        // Ignored kind, then every status bit at once, unused bits included
        send_word(bcmd_pkg::KIND_NONE, 8'hFF, 32'hFFFF_FFFF);
        scan(8'hFF, 32'hFFFF_FFFF);
        scan(8'hC0, 32'h0000_0000);
        buttons = 8'hC0;
        scan_ms = 32'h0000_0000;
    endtask

    task automatic run_random(input int count);
        int n;
        int pick;
        int bit_sel;
        int dir_bit;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_word(bcmd_pkg::KIND_ARP_USED, 8'($urandom), $urandom);
                n++;
            end else if (pick < 16) begin
                send_word(bcmd_pkg::KIND_PROG_USED, 8'($urandom), $urandom);
                n++;
            end else if (pick < 19) begin
                send_word(bcmd_pkg::KIND_NONE, 8'($urandom), $urandom);
                n++;
            end else if (pick < 24) begin
                // Noise: an arbitrary column word
                buttons = 8'($urandom);
                advance_time();
                scan(buttons, scan_ms);
                n++;
            end else if (pick < 27) begin
                // Run of presses in one direction to reach the clamp
                dir_bit = ($urandom_range(0, 1) != 0) ? bcmd_pkg::BIT_UP : bcmd_pkg::BIT_DOWN;
                buttons[bcmd_pkg::BIT_UP]   = 1'b0;
                buttons[bcmd_pkg::BIT_DOWN] = 1'b0;
                repeat (9) begin
                    buttons[dir_bit] = 1'b1;
                    advance_time();
                    scan(buttons, scan_ms);
                    buttons[dir_bit] = 1'b0;
                    advance_time();
                    scan(buttons, scan_ms);
                end
                n += 18;
            end else begin
                // Pause until the pipeline is empty, now and then
                if (pick < 29)
                    drain_results();
                // Scan that flips one status bit and now and then a second, which may undo the first
                bit_sel = ($urandom_range(0, 99) < 3) ? $urandom_range(6, 7)
                                                      : $urandom_range(0, 5);
                buttons[bit_sel] = ~buttons[bit_sel];
                if ($urandom_range(0, 3) == 0) begin
                    bit_sel = $urandom_range(0, 5);
                    buttons[bit_sel] = ~buttons[bit_sel];
                end
                advance_time();
                scan(buttons, scan_ms);
                n++;
            end
        end
    endtask

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.kind    = bcmd_pkg::KIND_SCAN;
        in_ch.status  = 8'h00;
        in_ch.now_ms  = 32'd0;
        out_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = bcmd_pkg::HOLD_RESET;
        i_rst_n       = 1'b0;
        src_idle_pct  = 38;
        sink_idle_pct = 65;
        hold_now      = bcmd_pkg::HOLD_RESET;
        scan_ms       = 32'd0;
        buttons       = 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words on the reset hold time
        run_directed();
        drain_results();

        // Zero hold: editor fires on the press word itself
        write_hold(16'd0);
        run_random(100);
        drain_results();

        // Swap the idle rates
        src_idle_pct  = 65;
        sink_idle_pct = 38;
        write_hold(16'hFFFF);
        run_random(100);
        drain_results();

        write_hold(16'($urandom_range(1, 5000)));
        run_random(100);
        drain_results();

        // Full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_hold(16'd1);
        run_random(100);
        drain_results();

        // Let the pipeline settle before the verdict
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[button_column_mode_decoder_core] OK");
        end else begin
            $display("[button_column_mode_decoder_core] ERROR");
        end
        $finish;
    end

    // Watchdog: end the run if the handshakes stop moving
    initial begin
        #6_000_000;
        $display("[button_column_mode_decoder_core] ERROR");
        $finish;
    end

endmodule
